// File: hw/rtl/gnab_pkg.sv
// shared constants and register indexes for the glyph nibble atlas blitter
`timescale 1ns / 1ps

package gnab_pkg;

    // atlas geometry
    localparam int IMAGE_WIDTH = 2016;
    localparam int TILE_HEIGHT = 48;
    localparam int SPLIT_INDEX = 7023;
    localparam int INDEX_BITS  = 25;

    localparam int FULL_TILE_W = 48;
    localparam int HALF_TILE_W = 24;

    // tiles per atlas row, at least one
    localparam int FULL_PER_ROW = (IMAGE_WIDTH / FULL_TILE_W) < 1 ? 1 : IMAGE_WIDTH / FULL_TILE_W;
    localparam int HALF_PER_ROW = (IMAGE_WIDTH / HALF_TILE_W) < 1 ? 1 : IMAGE_WIDTH / HALF_TILE_W;

    // full-width tile rows that sit above the half-width region
    localparam int FULL_ROWS = (SPLIT_INDEX + FULL_PER_ROW - 1) / FULL_PER_ROW;

    localparam int GLYPH_W = 14;
    localparam int COL_W   = $clog2(HALF_PER_ROW) < 1 ? 1 : $clog2(HALF_PER_ROW);
    localparam int X_W     = $clog2(IMAGE_WIDTH + 1);

    // index of the first pixel of a tile row, and the step between tile rows
    localparam logic [INDEX_BITS-1:0] ROW_STEP =
        INDEX_BITS'(longint'(TILE_HEIGHT) * longint'(IMAGE_WIDTH));
    localparam logic [INDEX_BITS-1:0] HALF_BASE =
        INDEX_BITS'(longint'(FULL_ROWS) * longint'(TILE_HEIGHT) * longint'(IMAGE_WIDTH));

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SIZE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SMALL_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPLIT_MODE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_GLYPHS = 3'd3;

    // configuration reset values
    localparam logic [5:0] FULL_SIZE_RESET   = 6'd24;
    localparam logic [4:0] SMALL_WIDTH_RESET = 5'd12;

endpackage

// File: hw/rtl/glyph_nibble_atlas_blitter_top.sv
// glyph nibble atlas blitter: nibble bytes in, atlas pixel index and alphas out
`timescale 1ns / 1ps

// Takes one packed glyph byte per cycle unless m_tready stalls the output and
// returns one beat per byte, passing an input register, then the address
// logic, then the output register. A new byte can be accepted every cycle
// when not stalled; the only recurrence is the glyph position counters.
// Tile origins are kept as running counters (column, pixel x and row base
// index for the full-width and the half-width region), so no division is
// needed. The configuration port is always ready and should only be written
// while no beat is in flight. After reset or a restart flag the first glyph
// lands in the top-left tile.
module glyph_nibble_atlas_blitter_top
    import gnab_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // byte input
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] packed_byte
    input  logic                 s_tuser,   // [0] restart
    // pixel pair output
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [55:0]          m_tdata,   // [24:0] pixel_index, [32:25] alpha_left,
                                            // [40:33] alpha_right, [48:41] colour_level
    output logic                 m_tlast,   // glyph_done
    output logic                 m_tuser,   // [0] half_width
    // register writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [5:0]           cfg_data
);

    // configuration registers
    logic [5:0] full_size_reg;
    logic [4:0] small_width_reg;
    logic       split_mode_reg;
    logic       white_glyphs_reg;

    // input stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_restart_reg;

    // glyph position state
    logic [GLYPH_W-1:0]    glyph_count_reg, glyph_count_next;
    logic [5:0]            col_reg, col_next;
    logic [5:0]            row_reg, row_next;
    logic [COL_W-1:0]      full_col_reg, full_col_next;
    logic [X_W-1:0]        full_x_reg, full_x_next;
    logic [INDEX_BITS-1:0] full_base_reg, full_base_next;
    logic [COL_W-1:0]      half_col_reg, half_col_next;
    logic [X_W-1:0]        half_x_reg, half_x_next;
    logic [INDEX_BITS-1:0] half_base_reg, half_base_next;

    // output stage
    logic                  out_valid_reg;
    logic [INDEX_BITS-1:0] out_index_reg;
    logic [7:0]            out_alpha_l_reg;
    logic [7:0]            out_alpha_r_reg;
    logic                  out_white_reg;
    logic                  out_done_reg;
    logic                  out_half_reg;

    // datapath signals
    logic                  advance;
    logic [GLYPH_W-1:0]    gc_eff;
    logic [5:0]            col_eff, row_eff;
    logic [COL_W-1:0]      fcol_eff, hcol_eff;
    logic [X_W-1:0]        fx_eff, hx_eff, tile_x;
    logic [INDEX_BITS-1:0] fbase_eff, hbase_eff, tile_base;
    logic                  half;
    logic [5:0]            tile_w, glyph_w;
    logic signed [7:0]     dx, dy, cx, cy, row_off;
    logic [INDEX_BITS-1:0] row_term, index;
    logic                  row_end, glyph_end;
    logic [GLYPH_W-1:0]    gc_inc;
    logic [7:0]            alpha_l, alpha_r;

    // handshake: output register decouples the two sides
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // restart clears the position before this byte
    always_comb begin
        if (in_restart_reg) begin
            gc_eff    = '0;
            col_eff   = '0;
            row_eff   = '0;
            fcol_eff  = '0;
            fx_eff    = '0;
            fbase_eff = '0;
            hcol_eff  = '0;
            hx_eff    = '0;
            hbase_eff = HALF_BASE;
        end else begin
            gc_eff    = glyph_count_reg;
            col_eff   = col_reg;
            row_eff   = row_reg;
            fcol_eff  = full_col_reg;
            fx_eff    = full_x_reg;
            fbase_eff = full_base_reg;
            hcol_eff  = half_col_reg;
            hx_eff    = half_x_reg;
            hbase_eff = half_base_reg;
        end
    end

    // tile selection and centring offsets (halved toward zero)
    always_comb begin
        half      = split_mode_reg && (gc_eff >= GLYPH_W'(SPLIT_INDEX));
        tile_w    = half ? 6'(HALF_TILE_W) : 6'(FULL_TILE_W);
        glyph_w   = half ? {1'b0, small_width_reg} : full_size_reg;
        tile_x    = half ? hx_eff : fx_eff;
        tile_base = half ? hbase_eff : fbase_eff;
        dx        = $signed({2'b00, tile_w}) - $signed({2'b00, glyph_w});
        dy        = $signed(8'(TILE_HEIGHT)) - $signed({2'b00, full_size_reg});
        cx        = (dx + $signed({7'b0, dx[7]})) >>> 1;
        cy        = (dy + $signed({7'b0, dy[7]})) >>> 1;
        row_off   = $signed({2'b00, row_eff}) + cy;
        row_term  = INDEX_BITS'({{(INDEX_BITS-8){row_off[7]}}, row_off}
                    * INDEX_BITS'(IMAGE_WIDTH));
        index     = tile_base + row_term
                    + INDEX_BITS'(tile_x)
                    + {{(INDEX_BITS-8){cx[7]}}, cx}
                    + INDEX_BITS'(col_eff);
        alpha_l   = {in_byte_reg[3:0], in_byte_reg[3:0]};
        alpha_r   = {in_byte_reg[7:4], in_byte_reg[7:4]};
    end

    // end of glyph row and of glyph
    always_comb begin
        row_end   = (7'(col_eff) + 7'd2) >= 7'(glyph_w);
        glyph_end = row_end && ((7'(row_eff) + 7'd1) >= 7'(full_size_reg));
        gc_inc    = gc_eff + 1'b1;
    end

    // next glyph position
    always_comb begin
        glyph_count_next = gc_eff;
        col_next         = col_eff + 6'd2;
        row_next         = row_eff;
        full_col_next    = fcol_eff;
        full_x_next      = fx_eff;
        full_base_next   = fbase_eff;
        half_col_next    = hcol_eff;
        half_x_next      = hx_eff;
        half_base_next   = hbase_eff;
        if (row_end) begin
            col_next = '0;
            row_next = row_eff + 6'd1;
        end
        if (glyph_end) begin
            row_next         = '0;
            glyph_count_next = gc_inc;
            // full-width tile follows the glyph count
            if (gc_inc == '0) begin
                full_col_next  = '0;
                full_x_next    = '0;
                full_base_next = '0;
            end else if (fcol_eff == COL_W'(FULL_PER_ROW - 1)) begin
                full_col_next  = '0;
                full_x_next    = '0;
                full_base_next = fbase_eff + ROW_STEP;
            end else begin
                full_col_next = fcol_eff + 1'b1;
                full_x_next   = fx_eff + X_W'(FULL_TILE_W);
            end
            // half-width tile counts from the split index
            if (gc_inc <= GLYPH_W'(SPLIT_INDEX)) begin
                half_col_next  = '0;
                half_x_next    = '0;
                half_base_next = HALF_BASE;
            end else if (hcol_eff == COL_W'(HALF_PER_ROW - 1)) begin
                half_col_next  = '0;
                half_x_next    = '0;
                half_base_next = hbase_eff + ROW_STEP;
            end else begin
                half_col_next = hcol_eff + 1'b1;
                half_x_next   = hx_eff + X_W'(HALF_TILE_W);
            end
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_size_reg    <= FULL_SIZE_RESET;
            small_width_reg  <= SMALL_WIDTH_RESET;
            split_mode_reg   <= 1'b1;
            white_glyphs_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_FULL_SIZE:    full_size_reg    <= cfg_data;
                REG_SMALL_WIDTH:  small_width_reg  <= cfg_data[4:0];
                REG_SPLIT_MODE:   split_mode_reg   <= cfg_data[0];
                REG_WHITE_GLYPHS: white_glyphs_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // input stage, position state and output stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            glyph_count_reg <= '0;
            col_reg         <= '0;
            row_reg         <= '0;
            full_col_reg    <= '0;
            full_x_reg      <= '0;
            full_base_reg   <= '0;
            half_col_reg    <= '0;
            half_x_reg      <= '0;
            half_base_reg   <= HALF_BASE;
        end else begin
            // output beat taken or replaced
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            // byte moves from the input register into the output register
            if (advance && in_valid_reg) begin
                glyph_count_reg <= glyph_count_next;
                col_reg         <= col_next;
                row_reg         <= row_next;
                full_col_reg    <= full_col_next;
                full_x_reg      <= full_x_next;
                full_base_reg   <= full_base_next;
                half_col_reg    <= half_col_next;
                half_x_reg      <= half_x_next;
                half_base_reg   <= half_base_next;
            end
            // new input beat
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg    <= s_tdata;
            in_restart_reg <= s_tuser;
        end
        if (advance && in_valid_reg) begin
            out_index_reg   <= index;
            out_alpha_l_reg <= alpha_l;
            out_alpha_r_reg <= alpha_r;
            out_white_reg   <= white_glyphs_reg;
            out_done_reg    <= glyph_end;
            out_half_reg    <= half;
        end
    end

    // output beat
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, {8{out_white_reg}}, out_alpha_r_reg, out_alpha_l_reg,
                       out_index_reg};
    assign m_tlast  = out_done_reg;
    assign m_tuser  = out_half_reg;

endmodule
